@@ rtl/sts_pkg.sv @@
// Package for the sorted table search block.
// Request and result types, opcodes and search states; no dependencies.
package sts_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam int IDX_W = 10;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] operand_value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] found_index;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_COMPARE
	} state_t;

endpackage

@@ rtl/sts_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/sts_search.sv @@
// Binary search sequencer: one table read and one compare per probe.
// Depends on sts_pkg; drives the read port of the table RAM.
module sts_search #(
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     go,
	input  logic signed [31:0]                       key,
	input  logic [$clog2(DEPTH+1)-1:0]               count,
	output logic                                     rd_en,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	input  logic signed [31:0]                       rd_data,
	output logic                                     busy,
	output logic                                     done,
	output sts_pkg::res_t                            res
);

	import sts_pkg::*;

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   low_q, end_q;
	logic [ADDR_W-1:0]  mid_q;
	logic signed [31:0] key_q;
	logic               done_q;
	res_t               res_q;

	logic [CNT_W-1:0]      span;
	logic [CNT_W-1:0]      mid_wide;
	logic [ADDR_W-1:0]     mid;
	logic                  empty;
	logic [ADDR_W+IDX_W-1:0] mid_ext;

	assign span     = end_q - low_q - CNT_W'(1);
	assign mid_wide = low_q + (span >> 1);
	assign mid      = mid_wide[ADDR_W-1:0];
	assign empty    = (end_q <= low_q);
	assign mid_ext  = {{IDX_W{1'b0}}, mid_q};

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = mid;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (empty) begin
					state_d = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				if (key_q == rd_data) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == ST_ISSUE) && empty) ||
			           ((state_q == ST_COMPARE) && (key_q == rd_data));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					low_q <= '0;
					end_q <= count;
					key_q <= key;
				end
			end
			ST_ISSUE: begin
				if (empty) begin
					res_q.found       <= 1'b0;
					res_q.found_index <= '0;
				end else begin
					mid_q <= mid;
				end
			end
			ST_COMPARE: begin
				if (key_q == rd_data) begin
					res_q.found       <= 1'b1;
					res_q.found_index <= mid_ext[IDX_W-1:0];
				end else if (key_q < rd_data) begin
					end_q <= CNT_W'(mid_q);
				end else begin
					low_q <= CNT_W'(mid_q) + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// Top level of the sorted table search block: entry count, table RAM, search.
// Depends on sts_pkg, sts_ram and sts_search.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------
//  request  | start, busy         | req (opcode, operand_value)
//  result   | done (one cycle)    | res (found, found_index)
//
// Clear and append leave busy low, so the next request can follow at once. A
// search alternates between reading the table RAM at the midpoint of the open
// range and comparing the key with the read data, and ends on a hit or once
// the range is empty.
// Reset empties the table; entries are undefined until appended.
// Results are strobed on done for one cycle and cannot be stalled.
module sorted_table_binary_search #(
	parameter int DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sts_pkg::req_t  req,
	output logic           done,
	output sts_pkg::res_t  res
);

	import sts_pkg::*;

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]   count_q;
	logic               accept;
	logic               wr_en;
	logic               go;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [31:0]        rd_data;

	assign accept = start && !busy;
	assign wr_en  = accept && (req.opcode == OP_APPEND) && (count_q < CNT_W'(DEPTH));
	assign go     = accept && (req.opcode == OP_SEARCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && (req.opcode == OP_CLEAR)) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	sts_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (req.operand_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sts_search #(
		.DEPTH (DEPTH)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.key     (req.operand_value),
		.count   (count_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.busy    (busy),
		.done    (done),
		.res     (res)
	);

endmodule

@@ tb/sorted_table_binary_search_tb.sv @@
// Testbench for sorted_table_binary_search: directed table, then random load and search sessions.
// Checks each search result against a pinned value or a local binary search on a shadow table.
// Depends on sts_pkg and the sorted_table_binary_search RTL.
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;
	import sts_pkg::*;

	localparam int DEPTH = 1024;
	localparam int ITEM_TARGET = 1800;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		req_t rq;
		logic pinned;
		res_t want;
	} dir_row_t;

	localparam int N_DIRECTED = 23;
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{'{OP_SEARCH, 32'sd0}, 1'b1, '{1'b0, 10'd0}},
		'{'{OP_UNUSED, 32'hffff_ffff}, 1'b0, '0},
		'{'{OP_APPEND, 32'h8000_0000}, 1'b0, '0},
		'{'{OP_APPEND, -32'sd5}, 1'b0, '0},
		'{'{OP_APPEND, 32'sd0}, 1'b0, '0},
		'{'{OP_APPEND, 32'sd7}, 1'b0, '0},
		'{'{OP_APPEND, 32'h7fff_ffff}, 1'b0, '0},
		'{'{OP_SEARCH, 32'h8000_0000}, 1'b1, '{1'b1, 10'd0}},
		'{'{OP_SEARCH, 32'h7fff_ffff}, 1'b1, '{1'b1, 10'd4}},
		'{'{OP_SEARCH, 32'sd0}, 1'b1, '{1'b1, 10'd2}},
		'{'{OP_SEARCH, 32'sd1}, 1'b1, '{1'b0, 10'd0}},
		'{'{OP_UNUSED, 32'sd0}, 1'b0, '0},
		'{'{OP_SEARCH, 32'sd7}, 1'b1, '{1'b1, 10'd3}},
		'{'{OP_CLEAR, 32'sd0}, 1'b0, '0},
		'{'{OP_SEARCH, 32'sd0}, 1'b1, '{1'b0, 10'd0}},
		'{'{OP_APPEND, 32'sd3}, 1'b0, '0},
		'{'{OP_APPEND, 32'sd1}, 1'b0, '0},
		'{'{OP_APPEND, 32'sd3}, 1'b0, '0},
		'{'{OP_SEARCH, 32'sd1}, 1'b0, '0},
		'{'{OP_SEARCH, 32'sd3}, 1'b0, '0},
		'{'{OP_APPEND, -32'sd5}, 1'b0, '0},
		'{'{OP_SEARCH, -32'sd5}, 1'b0, '0},
		'{'{OP_CLEAR, 32'hffff_ffff}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t res;

	logic fixed_valid = 1'b0;
	res_t fixed_res = '0;

	logic signed [31:0] shadow_table [DEPTH];
	int shadow_count = 0;
	res_t expected_lookups [$];
	int mismatches = 0;
	int items_sent = 0;
	int gap_pct = 0;
	int cycles = 0;

	sorted_table_binary_search #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic res_t predict_lookup(input logic signed [31:0] key);
		int lo;
		int hi;
		int mid;
		res_t r;
		r = '0;
		lo = 0;
		hi = shadow_count - 1;
		while (hi >= lo) begin
			mid = lo + (hi - lo) / 2;
			if (key == shadow_table[mid]) begin
				r.found = 1'b1;
				r.found_index = mid[9:0];
				lo = hi + 1;
			end else if (key < shadow_table[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : watch_results
		res_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_lookups.size() == 0) begin
					$error("result with no search pending: found=%0d found_index=%0d",
						res.found, res.found_index);
					mismatches++;
				end else begin
					want = expected_lookups.pop_front();
					if (res.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, res.found);
						mismatches++;
					end
					if (res.found_index !== want.found_index) begin
						$error("found_index: expected %0d, got %0d",
							want.found_index, res.found_index);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				case (req.opcode)
					OP_CLEAR: shadow_count = 0;
					OP_APPEND: begin
						if (shadow_count < DEPTH) begin
							shadow_table[shadow_count] = req.operand_value;
							shadow_count++;
						end
					end
					OP_SEARCH: begin
						if (fixed_valid)
							expected_lookups.insert(expected_lookups.size(), fixed_res);
						else
							expected_lookups.insert(expected_lookups.size(),
								predict_lookup(req.operand_value));
					end
					default: ;
				endcase
			end
		end
	end

	task automatic issue(input req_t r, input logic pin, input res_t want);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		fixed_valid <= pin;
		fixed_res <= want;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (r.opcode != OP_UNUSED)
			items_sent++;
	endtask

	task automatic maybe_noise();
		req_t r;
		if ($urandom_range(0, 24) == 0) begin
			r.opcode = OP_UNUSED;
			r.operand_value = $urandom;
			issue(r, 1'b0, '0);
		end
	endtask

	task automatic run_session(input int n_load, input int n_search);
		int vals [$];
		int idx;
		int pick;
		req_t r;
		r.opcode = OP_CLEAR;
		r.operand_value = $urandom;
		issue(r, 1'b0, '0);
		for (int i = 0; i < n_load; i++)
			vals.insert(vals.size(), int'($urandom));
		if (n_load > 1 && $urandom_range(0, 5) == 0) begin
			vals[0] = int'(32'h8000_0000);
			vals[n_load-1] = int'(32'h7fff_ffff);
		end
		vals.sort();
		foreach (vals[i]) begin
			maybe_noise();
			r.opcode = OP_APPEND;
			r.operand_value = ($urandom_range(0, 19) == 0) ? $urandom : vals[i];
			issue(r, 1'b0, '0);
		end
		repeat (n_search) begin
			maybe_noise();
			r.opcode = OP_SEARCH;
			pick = $urandom_range(0, 9);
			idx = (vals.size() > 0) ? $urandom_range(0, vals.size() - 1) : 0;
			if (vals.size() == 0 || pick >= 8)
				r.operand_value = $urandom;
			else if (pick < 6)
				r.operand_value = vals[idx];
			else
				r.operand_value = vals[idx] + ((pick == 6) ? 1 : -1);
			issue(r, 1'b0, '0);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 30;
		for (int i = 0; i < N_DIRECTED; i++)
			issue(DIRECTED[i].rq, DIRECTED[i].pinned, DIRECTED[i].want);

		run_session(DEPTH + 4, 60);
		while (items_sent < ITEM_TARGET) begin
			if (items_sent > ITEM_TARGET - 250)
				gap_pct = 0;
			else
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
			run_session(($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
				: $urandom_range(0, 40), $urandom_range(5, 20));
		end

		start <= 1'b0;
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sts_pkg.sv
rtl/sts_ram.sv
rtl/sts_search.sv
rtl/sorted_table_binary_search.sv
tb/sorted_table_binary_search_tb.sv
